// ===== src/imu_pc_pkg.sv =====
// Shared types, reset values and constants of the IMU posture classifier.
// No dependencies; every other file uses this package.

package imu_pc_pkg;

  // Default depth of the arcsine table
  localparam int unsigned ASIN_ENTRIES_DEFAULT = 1024;

  // One g in Q2.14 and ninety degrees in 1/128 degree
  localparam int unsigned ONE_G        = 16384;
  localparam int unsigned QUARTER_TURN = 11520;

  // Degree step of 1/128 expressed in radians, Q30
  localparam longint unsigned SIN_ARG_SCALE = 64'd146409;

  // Yaw step is d * 9 / 65: ceil(2^26 / 65) with a 26 bit shift is exact below 2^20
  localparam logic [19:0] YAW_RECIP       = 20'd1032445;
  localparam int unsigned YAW_RECIP_SHIFT = 26;

  // Configuration register map
  typedef enum logic [2:0] {
    REG_GYRO_ZERO_Z      = 3'd0,
    REG_MOTION_THRESH_SQ = 3'd1,
    REG_ANGLE_LIMIT      = 3'd2,
    REG_Z_UPRIGHT_LIMIT  = 3'd3,
    REG_Z_FACEUP_LIMIT   = 3'd4,
    REG_Z_SIDE_LIMIT     = 3'd5,
    REG_ACCEL_Y_OFFSET   = 3'd6,
    REG_ACCEL_X_OFFSET   = 3'd7
  } cfg_reg_t;

  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values
  localparam logic signed [15:0] GYRO_ZERO_Z_RST      = 16'sd0;
  localparam logic [31:0]        MOTION_THRESH_SQ_RST = 32'd10240000;
  localparam logic [13:0]        ANGLE_LIMIT_RST      = 14'd5760;
  localparam logic signed [15:0] Z_UPRIGHT_LIMIT_RST  = -16'sd11469;
  localparam logic signed [15:0] Z_FACEUP_LIMIT_RST   = -16'sd8192;
  localparam logic signed [15:0] Z_SIDE_LIMIT_RST     = -16'sd4915;
  localparam logic signed [15:0] ACCEL_Y_OFFSET_RST   = 16'sd1229;
  localparam logic signed [15:0] ACCEL_X_OFFSET_RST   = 16'sd1393;

  // Posture codes
  typedef enum logic [2:0] {
    POSTURE_UPRIGHT   = 3'd0,
    POSTURE_FACE_UP   = 3'd1,
    POSTURE_FACE_DOWN = 3'd2,
    POSTURE_LEFT      = 3'd3,
    POSTURE_RIGHT     = 3'd4,
    POSTURE_UNDEFINED = 3'd5
  } posture_t;

  // Load enables of the middle pipeline stages
  typedef struct packed {
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

// ===== src/imu_pc_if.sv =====
// Valid/ready channel interfaces for IMU samples and classifier results.
// Depends on imu_pc_pkg for the posture type.

interface imu_pc_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  output ready);
endinterface

interface imu_pc_result_if;
  logic                  valid;
  logic                  ready;
  logic signed [14:0]    pitch;
  logic signed [14:0]    roll;
  logic signed [31:0]    yaw;
  logic                  moving;
  imu_pc_pkg::posture_t  posture;

  modport source (output valid, pitch, roll, yaw, moving, posture, input ready);
  modport sink   (input valid, pitch, roll, yaw, moving, posture, output ready);
endinterface

// ===== src/imu_pc_asin.sv =====
// Arcsine of a clamped Q2.14 value in 1/128 degree: table read plus linear interpolation.
// Depends on imu_pc_pkg; the table is built at elaboration from a Taylor-series sine.

module imu_pc_asin #(
  parameter int unsigned ASIN_TABLE_ENTRIES = imu_pc_pkg::ASIN_ENTRIES_DEFAULT
) (
  input  logic                  clk,
  input  imu_pc_pkg::stage_en_t en,
  input  logic signed [15:0]    arg,
  output logic signed [14:0]    angle
);
  import imu_pc_pkg::*;

  localparam int unsigned AW = $clog2(ASIN_TABLE_ENTRIES);
  localparam int unsigned PW = AW + 15;

  typedef logic [13:0] rom_t [ASIN_TABLE_ENTRIES];

  // Integer Taylor series of sin, Q30, six correction terms
  function automatic logic [63:0] sine_q30(input logic [13:0] a);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x    = 64'(a) * SIN_ARG_SCALE;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    return (sum < 0) ? 64'd0 : 64'(sum);
  endfunction

  // Smallest angle whose sine reaches each table step
  function automatic rom_t build_rom();
    rom_t        tbl;
    logic [63:0] target;
    logic [14:0] lo;
    logic [14:0] hi;
    logic [14:0] mid;
    for (int i = 0; i < ASIN_TABLE_ENTRIES; i++) begin
      target = (64'(i) << 30) / 64'(ASIN_TABLE_ENTRIES - 1);
      lo     = 15'd0;
      hi     = 15'(QUARTER_TURN);
      mid    = 15'd0;
      for (int k = 0; k < 15; k++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (sine_q30(mid[13:0]) >= target) hi = mid;
          else lo = mid + 15'd1;
        end
      end
      tbl[i] = lo[13:0];
    end
    return tbl;
  endfunction

  localparam rom_t ROM = build_rom();

  // Magnitude, table index and fraction
  logic [14:0]    mag;
  logic [PW-1:0]  pos;
  logic [AW-1:0]  idx;
  logic [AW-1:0]  idx_hi;
  logic [13:0]    frac;

  assign mag    = arg[15] ? 15'(-arg) : 15'(arg);
  assign pos    = PW'(mag) * PW'(ASIN_TABLE_ENTRIES - 1);
  assign idx    = pos[AW+13:14];
  assign frac   = pos[13:0];
  assign idx_hi = (idx == AW'(ASIN_TABLE_ENTRIES - 1)) ? idx : idx + AW'(1);

  // Stage 2: registered table reads
  logic [13:0] t_lo;
  logic [13:0] t_hi;
  logic [13:0] frac2;
  logic        neg2;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      t_lo  <= ROM[idx];
      t_hi  <= ROM[idx_hi];
      frac2 <= frac;
      neg2  <= arg[15];
    end
  end

  // Stage 3: interpolation product, rounded
  logic signed [14:0] diff;
  logic signed [29:0] prod;
  logic [28:0]        rounded;
  logic [13:0]        t_lo3;
  logic [14:0]        step3;
  logic               neg3;

  assign diff    = signed'({1'b0, t_hi}) - signed'({1'b0, t_lo});
  assign prod    = diff * signed'({1'b0, frac2});
  assign rounded = prod[28:0] + 29'd8192;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      t_lo3 <= t_lo;
      step3 <= rounded[28:14];
      neg3  <= neg2;
    end
  end

  // Add base and restore the sign
  logic [14:0] mag_angle;

  assign mag_angle = {1'b0, t_lo3} + step3;
  assign angle     = neg3 ? signed'(-mag_angle) : signed'(mag_angle);

endmodule

// ===== src/imu_posture_classifier.sv =====
// Top level of the IMU posture classifier: pipeline, configuration and yaw state.
// Depends on imu_pc_pkg, imu_pc_if.sv and imu_pc_asin.
//
// Usage: each item on the sample channel is one IMU sample (accel x/y/z in Q2.14 g,
// gyro x/y/z in 1/128 dps). For every item the result channel delivers one item:
// pitch and roll in 1/128 degree, the integrated yaw, the motion flag and the posture.
// Both channels use valid/ready; an item moves at a clock edge with both high.
// The pipeline has four registered stages: input, table read, interpolation and
// the result register, which each accepted sample passes through in that order. One
// item is accepted per cycle for as long as the receiver takes results. Per stage
// the table read and the interpolation multiplier set the pace.
// When the receiver stalls, the stages fill behind the result register and
// sample.ready falls only once all four hold an item.
// Configuration: cfg_write, cfg_index and cfg_data write one register per cycle;
// write only while no item is in flight.
// Reset (rst, synchronous) empties the pipeline, clears yaw to zero and restores
// every configuration register to its default.

module imu_posture_classifier #(
  parameter int unsigned ASIN_TABLE_ENTRIES = imu_pc_pkg::ASIN_ENTRIES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  imu_pc_pkg::cfg_reg_t               cfg_index,
  input  logic [imu_pc_pkg::CFG_DATA_W-1:0]  cfg_data,
  imu_pc_sample_if.sink                      sample,
  imu_pc_result_if.source                    result
);
  import imu_pc_pkg::*;

  // Clamp to plus or minus one g
  function automatic logic signed [15:0] clamp_g(input logic signed [16:0] v);
    logic signed [16:0] lim;
    lim = 17'sd16384;
    if (v > lim) return 16'sd16384;
    else if (v < -lim) return -16'sd16384;
    else return v[15:0];
  endfunction

  // Configuration registers
  logic signed [15:0] gyro_zero_z;
  logic [31:0]        motion_threshold_sq;
  logic [13:0]        angle_limit;
  logic signed [15:0] z_upright_limit;
  logic signed [15:0] z_faceup_limit;
  logic signed [15:0] z_side_limit;
  logic signed [15:0] accel_y_offset;
  logic signed [15:0] accel_x_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_zero_z         <= GYRO_ZERO_Z_RST;
      motion_threshold_sq <= MOTION_THRESH_SQ_RST;
      angle_limit         <= ANGLE_LIMIT_RST;
      z_upright_limit     <= Z_UPRIGHT_LIMIT_RST;
      z_faceup_limit      <= Z_FACEUP_LIMIT_RST;
      z_side_limit        <= Z_SIDE_LIMIT_RST;
      accel_y_offset      <= ACCEL_Y_OFFSET_RST;
      accel_x_offset      <= ACCEL_X_OFFSET_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GYRO_ZERO_Z:      gyro_zero_z         <= cfg_data[15:0];
        REG_MOTION_THRESH_SQ: motion_threshold_sq <= cfg_data[31:0];
        REG_ANGLE_LIMIT:      angle_limit         <= cfg_data[13:0];
        REG_Z_UPRIGHT_LIMIT:  z_upright_limit     <= cfg_data[15:0];
        REG_Z_FACEUP_LIMIT:   z_faceup_limit      <= cfg_data[15:0];
        REG_Z_SIDE_LIMIT:     z_side_limit        <= cfg_data[15:0];
        REG_ACCEL_Y_OFFSET:   accel_y_offset      <= cfg_data[15:0];
        REG_ACCEL_X_OFFSET:   accel_x_offset      <= cfg_data[15:0];
      endcase
    end
  end

  // Stage valids and advance chain
  logic v1, v2, v3;
  logic adv1, adv2, adv3, adv4;
  stage_en_t en;

  assign adv4         = !result.valid || result.ready;
  assign adv3         = !v3 || adv4;
  assign adv2         = !v2 || adv3;
  assign adv1         = !v1 || adv2;
  assign sample.ready = adv1;
  assign en.s2        = adv2;
  assign en.s3        = adv3;

  // Stage 1: input register
  logic signed [15:0] ax1, ay1, az1, gx1, gy1, gz1;

  always_ff @(posedge clk) begin
    if (adv1) begin
      ax1 <= sample.accel_x;
      ay1 <= sample.accel_y;
      az1 <= sample.accel_z;
      gx1 <= sample.gyro_x;
      gy1 <= sample.gyro_y;
      gz1 <= sample.gyro_z;
    end
  end

  // Tilt arguments, clamped
  logic signed [16:0] y_raw, x_raw;
  logic signed [15:0] pitch_arg, roll_arg;

  assign y_raw     = 17'(ay1) - 17'(accel_y_offset);
  assign x_raw     = 17'(ax1) + 17'(accel_x_offset);
  assign pitch_arg = clamp_g(y_raw);
  assign roll_arg  = clamp_g(x_raw);

  logic signed [14:0] pitch3, roll3;

  imu_pc_asin #(.ASIN_TABLE_ENTRIES(ASIN_TABLE_ENTRIES)) u_pitch_asin (
    .clk   (clk),
    .en    (en),
    .arg   (pitch_arg),
    .angle (pitch3)
  );

  imu_pc_asin #(.ASIN_TABLE_ENTRIES(ASIN_TABLE_ENTRIES)) u_roll_asin (
    .clk   (clk),
    .en    (en),
    .arg   (roll_arg),
    .angle (roll3)
  );

  // Gyro squares and scaled yaw rate
  logic signed [31:0] sqx, sqy, sqz;
  logic signed [16:0] rate_d;
  logic signed [20:0] rate_n;
  logic               rate_neg;
  logic [19:0]        rate_abs;

  assign sqx      = gx1 * gx1;
  assign sqy      = gy1 * gy1;
  assign sqz      = gz1 * gz1;
  assign rate_d   = 17'(gz1) - 17'(gyro_zero_z);
  assign rate_n   = (21'(rate_d) <<< 3) + 21'(rate_d);
  assign rate_neg = rate_n[20];
  assign rate_abs = (rate_neg ? 20'(-rate_n) : 20'(rate_n)) + 20'd32;

  // Stage 2: squares and rounded rate magnitude
  logic [30:0]        sqx2, sqy2, sqz2;
  logic [19:0]        rate_abs2;
  logic               rate_neg2;
  logic signed [15:0] az2;

  always_ff @(posedge clk) begin
    if (adv2) begin
      sqx2      <= sqx[30:0];
      sqy2      <= sqy[30:0];
      sqz2      <= sqz[30:0];
      rate_abs2 <= rate_abs;
      rate_neg2 <= rate_neg;
      az2       <= az1;
    end
  end

  // Motion test and divide by 65 through the reciprocal
  logic [31:0] mag_sq;
  logic        moving2;
  logic [39:0] quot_prod;

  assign mag_sq    = 32'(sqx2) + 32'(sqy2) + 32'(sqz2);
  assign moving2   = mag_sq > motion_threshold_sq;
  assign quot_prod = 40'(rate_abs2) * 40'(YAW_RECIP);

  // Stage 3
  logic [13:0]        quot3;
  logic               rate_neg3;
  logic               moving3;
  logic signed [15:0] az3;

  always_ff @(posedge clk) begin
    if (adv3) begin
      quot3     <= quot_prod[YAW_RECIP_SHIFT+13:YAW_RECIP_SHIFT];
      rate_neg3 <= rate_neg2;
      moving3   <= moving2;
      az3       <= az2;
    end
  end

  // Yaw update
  logic [31:0] yaw_acc;
  logic [31:0] yaw_inc;
  logic [31:0] yaw_next;

  assign yaw_inc  = rate_neg3 ? -32'(quot3) : 32'(quot3);
  assign yaw_next = moving3 ? yaw_acc + yaw_inc : yaw_acc;

  // Posture: ordered compares, last match wins
  logic signed [15:0] p16, r16, p_abs, r_abs, lim16;
  posture_t           posture_next;

  assign p16   = 16'(pitch3);
  assign r16   = 16'(roll3);
  assign p_abs = p16[15] ? -p16 : p16;
  assign r_abs = r16[15] ? -r16 : r16;
  assign lim16 = signed'({2'b00, angle_limit});

  always_comb begin
    posture_next = POSTURE_UNDEFINED;
    if (!moving3) begin
      if (p_abs < lim16 && az3 < z_upright_limit) posture_next = POSTURE_UPRIGHT;
      if (r_abs < lim16 && az3 > z_faceup_limit)  posture_next = POSTURE_FACE_UP;
      if (p16 < -lim16 && r_abs < lim16)          posture_next = POSTURE_FACE_DOWN;
      if (r16 < -lim16 && az3 > z_side_limit)     posture_next = POSTURE_LEFT;
      if (r16 > lim16)                            posture_next = POSTURE_RIGHT;
    end
  end

  // Valids and yaw state
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result.valid <= 1'b0;
      yaw_acc      <= 32'd0;
    end else begin
      if (adv1) v1 <= sample.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) result.valid <= v3;
      if (adv4 && v3) yaw_acc <= yaw_next;
    end
  end

  // Stage 4: result register
  always_ff @(posedge clk) begin
    if (adv4) begin
      result.pitch   <= pitch3;
      result.roll    <= roll3;
      result.yaw     <= signed'(yaw_next);
      result.moving  <= moving3;
      result.posture <= posture_next;
    end
  end

`ifndef SYNTHESIS
  // Yaw moves only when a moving item enters the result register
  assert property (@(posedge clk) disable iff (rst)
    !(adv4 && v3 && moving3) |=> $stable(yaw_acc))
    else $error("yaw changed without a moving item");

  // A delivered moving result carries undefined posture
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.moving |-> result.posture == POSTURE_UNDEFINED)
    else $error("posture defined while moving");

  // Delivered yaw matches the accumulator it left behind
  assert property (@(posedge clk) disable iff (rst)
    adv4 && v3 |=> result.yaw == signed'(yaw_acc))
    else $error("result yaw differs from accumulator");

  // An accepted item occupies the input stage
  assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> v1)
    else $error("accepted item lost at input stage");

  // Reset empties the result register
  assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid after reset");
`endif

endmodule

// ===== bench/imu_posture_checker.sv =====
`timescale 1ns / 1ps
// Watches the sample, result and register-write ports of the posture classifier.
// Predicts pitch, roll, yaw, motion and posture per sample and compares results in order.
// Depends on imu_pc_pkg and the channel interfaces in imu_pc_if.sv.

module imu_posture_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  imu_pc_pkg::cfg_reg_t              cfg_index,
  input  logic [imu_pc_pkg::CFG_DATA_W-1:0] cfg_data,
  imu_pc_sample_if                          smp,
  imu_pc_result_if                          res,
  output int                                mismatches,
  output int                                samples_taken,
  output int                                results_seen
);
  import imu_pc_pkg::*;

  localparam int unsigned TABLE_DEPTH      = ASIN_ENTRIES_DEFAULT;
  localparam int          FULL_G           = 16384;
  localparam int          RIGHT_ANGLE      = 11520;
  localparam longint unsigned STEP_RAD_Q30 = 64'd146409;

  typedef struct packed {
    logic signed [14:0] pitch;
    logic signed [14:0] roll;
    logic [31:0]        yaw;
    logic               moving;
    posture_t           posture;
  } pose_t;

  // Arcsine table, register copies and yaw state
  int unsigned        arc_rom [TABLE_DEPTH];
  logic signed [15:0] zero_z;
  logic [31:0]        motion_thresh;
  logic [13:0]        angle_lim;
  logic signed [15:0] z_upright;
  logic signed [15:0] z_faceup;
  logic signed [15:0] z_side;
  logic signed [15:0] y_offset;
  logic signed [15:0] x_offset;
  logic [31:0]        yaw_acc;

  pose_t pose_fifo [$];
  pose_t want;
  pose_t got;

  initial mismatches = 0;

  task automatic note_mismatch(input string what);
    mismatches++;
    $display("%0t ns: pose mismatch: %s", $time, what);
  endtask

  // Truncated Taylor sine of an angle in 1/128 degree, Q30
  function automatic longint unsigned sine_q30(input int unsigned a);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    int              k;
    x = longint'(a) * STEP_RAD_Q30;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc -= longint'(term);
      else            acc += longint'(term);
    end
    return (acc < 0) ? 64'd0 : longint'(acc);
  endfunction

  // Each entry holds the smallest angle whose sine reaches its share of one
  initial begin : fill_arc_rom
    int unsigned     i;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     mid;
    longint unsigned target;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      target = (longint'(i) << 30) / longint'(TABLE_DEPTH - 1);
      lo = 0;
      hi = RIGHT_ANGLE;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (sine_q30(mid) >= target) hi = mid;
        else                         lo = mid + 1;
      end
      arc_rom[i] = lo;
    end
  end

  // Clamp to one g, then look up and interpolate the arcsine
  function automatic int arcsine_deg(input int v);
    int          c;
    int unsigned m;
    int unsigned p;
    int unsigned idx;
    int unsigned frac;
    int unsigned diff;
    int          r;
    c = (v > FULL_G) ? FULL_G : ((v < -FULL_G) ? -FULL_G : v);
    m = (c < 0) ? -c : c;
    p = m * (TABLE_DEPTH - 1);
    idx = p >> 14;
    frac = p & 32'd16383;
    if (idx >= TABLE_DEPTH - 1) begin
      r = arc_rom[TABLE_DEPTH - 1];
    end else begin
      diff = arc_rom[idx + 1] - arc_rom[idx];
      r = arc_rom[idx] + int'((diff * frac + 32'd8192) >> 14);
    end
    return (c < 0) ? -r : r;
  endfunction

  // Work out the result of one sample and advance the yaw integral
  function automatic pose_t classify_sample(input int ax, input int ay, input int az,
                                            input int gx, input int gy, input int gz);
    int     pitch_a;
    int     roll_a;
    int     lim;
    int     abs_pitch;
    int     abs_roll;
    longint mag;
    longint n;
    longint inc;
    pose_t  r;
    pitch_a = arcsine_deg(ay - int'(y_offset));
    roll_a = arcsine_deg(ax + int'(x_offset));
    abs_pitch = (pitch_a < 0) ? -pitch_a : pitch_a;
    abs_roll = (roll_a < 0) ? -roll_a : roll_a;
    lim = int'(angle_lim);
    mag = longint'(gx) * gx + longint'(gy) * gy + longint'(gz) * gz;
    r.moving = (mag > longint'(motion_thresh));
    if (r.moving) begin
      // Round the 9/65 step to nearest, away from zero on the halves
      n = (longint'(gz) - longint'(zero_z)) * 9;
      inc = (n >= 0) ? (n + 32) / 65 : -((-n + 32) / 65);
      yaw_acc += inc[31:0];
      r.posture = POSTURE_UNDEFINED;
    end else begin
      // Ordered compares: the last one that holds decides
      r.posture = POSTURE_UNDEFINED;
      if (abs_pitch < lim && az < int'(z_upright)) r.posture = POSTURE_UPRIGHT;
      if (abs_roll < lim && az > int'(z_faceup))   r.posture = POSTURE_FACE_UP;
      if (pitch_a < -lim && abs_roll < lim)        r.posture = POSTURE_FACE_DOWN;
      if (roll_a < -lim && az > int'(z_side))      r.posture = POSTURE_LEFT;
      if (roll_a > lim)                            r.posture = POSTURE_RIGHT;
    end
    r.pitch = pitch_a[14:0];
    r.roll = roll_a[14:0];
    r.yaw = yaw_acc;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pose_fifo.delete();
      zero_z        = GYRO_ZERO_Z_RST;
      motion_thresh = MOTION_THRESH_SQ_RST;
      angle_lim     = ANGLE_LIMIT_RST;
      z_upright     = Z_UPRIGHT_LIMIT_RST;
      z_faceup      = Z_FACEUP_LIMIT_RST;
      z_side        = Z_SIDE_LIMIT_RST;
      y_offset      = ACCEL_Y_OFFSET_RST;
      x_offset      = ACCEL_X_OFFSET_RST;
      yaw_acc       = '0;
      samples_taken <= 0;
      results_seen  <= 0;
    end else begin
      // Retire the oldest prediction against the item on the result channel
      if (res.valid && res.ready) begin
        results_seen <= results_seen + 1;
        if (pose_fifo.size() == 0) begin
          note_mismatch("result item with no sample outstanding");
        end else begin
          want = pose_fifo.pop_front();
          got.pitch = res.pitch;
          got.roll = res.roll;
          got.yaw = res.yaw;
          got.moving = res.moving;
          got.posture = res.posture;
          if (got.pitch !== want.pitch)
            note_mismatch($sformatf("pitch %0d, predicted %0d", got.pitch, want.pitch));
          if (got.roll !== want.roll)
            note_mismatch($sformatf("roll %0d, predicted %0d", got.roll, want.roll));
          if (got.yaw !== want.yaw)
            note_mismatch($sformatf("yaw %0d, predicted %0d",
                                    $signed(got.yaw), $signed(want.yaw)));
          if (got.moving !== want.moving)
            note_mismatch($sformatf("moving %b, predicted %b", got.moving, want.moving));
          if (got.posture !== want.posture)
            note_mismatch($sformatf("posture %0d, predicted %0d",
                                    got.posture, want.posture));
        end
      end
      // Predict each accepted sample
      if (smp.valid && smp.ready) begin
        samples_taken <= samples_taken + 1;
        pose_fifo.push_back(classify_sample(int'(smp.accel_x), int'(smp.accel_y),
                                            int'(smp.accel_z), int'(smp.gyro_x),
                                            int'(smp.gyro_y), int'(smp.gyro_z)));
      end
      // Track register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_GYRO_ZERO_Z:      zero_z        = cfg_data[15:0];
          REG_MOTION_THRESH_SQ: motion_thresh = cfg_data[31:0];
          REG_ANGLE_LIMIT:      angle_lim     = cfg_data[13:0];
          REG_Z_UPRIGHT_LIMIT:  z_upright     = cfg_data[15:0];
          REG_Z_FACEUP_LIMIT:   z_faceup      = cfg_data[15:0];
          REG_Z_SIDE_LIMIT:     z_side        = cfg_data[15:0];
          REG_ACCEL_Y_OFFSET:   y_offset      = cfg_data[15:0];
          REG_ACCEL_X_OFFSET:   x_offset      = cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== bench/tb_imu_posture_classifier.sv =====
`timescale 1ns / 1ps
// Top of the posture classifier bench: clock, reset, samples, register settings, stalls.
// Depends on imu_pc_pkg, imu_pc_if.sv, the classifier RTL and imu_posture_checker.

module tb_imu_posture_classifier;
  import imu_pc_pkg::*;

  localparam int PER_SETTING = 66;
  localparam int RIGHT_ANGLE = 11520;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
  } imu_frame_t;

  typedef enum int {TAKE_ALL, TAKE_MOST, TAKE_FEW, TAKE_PATTERN} stall_style_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int samples_taken;
  int results_seen;
  int burst_left;
  int settings_used;
  int hold_left;
  int beat;
  stall_style_t stall_style;

  imu_pc_sample_if smp ();
  imu_pc_result_if res ();

  imu_posture_classifier DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (smp),
    .result    (res)
  );

  imu_posture_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .smp           (smp),
    .res           (res),
    .mismatches    (mismatches),
    .samples_taken (samples_taken),
    .results_seen  (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: switch between randomly chosen stall styles
  initial begin
    res.ready <= 1'b0;
    hold_left = 0;
    beat = 0;
    stall_style = TAKE_ALL;
    forever begin
      @(posedge clk);
      if (hold_left == 0) begin
        stall_style = stall_style_t'($urandom_range(0, 3));
        hold_left = $urandom_range(16, 96);
      end
      hold_left--;
      beat++;
      case (stall_style)
        TAKE_ALL:  res.ready <= 1'b1;
        TAKE_MOST: res.ready <= ($urandom_range(0, 3) != 0);
        TAKE_FEW:  res.ready <= ($urandom_range(0, 3) == 0);
        default:   res.ready <= (beat % 5 < 3);
      endcase
    end
  end

  function automatic imu_frame_t frame(input int ax, input int ay, input int az,
                                       input int gx, input int gy, input int gz);
    imu_frame_t f;
    f.ax = ax[15:0];
    f.ay = ay[15:0];
    f.az = az[15:0];
    f.gx = gx[15:0];
    f.gy = gy[15:0];
    f.gz = gz[15:0];
    return f;
  endfunction

  // Gravity-like accel and calm gyro in half the frames each, with plain noise otherwise
  function automatic imu_frame_t random_frame();
    int acc [3];
    int gyr [3];
    int pick;
    int axis;
    int i;
    pick = $urandom_range(0, 19);
    axis = $urandom_range(0, 2);
    for (i = 0; i < 3; i++) begin
      if (pick < 10)      acc[i] = int'($urandom_range(0, 10000)) - 5000;
      else if (pick < 17) acc[i] = int'($urandom_range(0, 40000)) - 20000;
      else                acc[i] = int'($urandom_range(0, 65535)) - 32768;
    end
    if (pick < 10)
      acc[axis] = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(13000, 18000));
    pick = $urandom_range(0, 19);
    for (i = 0; i < 3; i++) begin
      if (pick < 10)      gyr[i] = int'($urandom_range(0, 3600)) - 1800;
      else if (pick < 16) gyr[i] = int'($urandom_range(0, 12000)) - 6000;
      else                gyr[i] = int'($urandom_range(0, 65535)) - 32768;
    end
    return frame(acc[0], acc[1], acc[2], gyr[0], gyr[1], gyr[2]);
  endfunction

  // Present one sample, with a random gap at the end of each burst
  task automatic send_frame(input imu_frame_t f);
    if (burst_left == 0) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    smp.valid   <= 1'b1;
    smp.accel_x <= f.ax;
    smp.accel_y <= f.ay;
    smp.accel_z <= f.az;
    smp.gyro_x  <= f.gx;
    smp.gyro_y  <= f.gy;
    smp.gyro_z  <= f.gz;
    do @(posedge clk); while (!smp.ready);
  endtask

  // Drop valid and hold until every result is back
  task automatic settle();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (samples_taken - results_seen > 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Write all eight registers; junk in the unused upper bits must be ignored
  task automatic apply_settings(input int zero, input logic [31:0] thr, input int lim,
                                input int zu, input int zf, input int zs,
                                input int yo, input int xo);
    write_reg(REG_GYRO_ZERO_Z,      {16'($urandom), zero[15:0]});
    write_reg(REG_MOTION_THRESH_SQ, thr);
    write_reg(REG_ANGLE_LIMIT,      {18'($urandom), lim[13:0]});
    write_reg(REG_Z_UPRIGHT_LIMIT,  {16'($urandom), zu[15:0]});
    write_reg(REG_Z_FACEUP_LIMIT,   {16'($urandom), zf[15:0]});
    write_reg(REG_Z_SIDE_LIMIT,     {16'($urandom), zs[15:0]});
    write_reg(REG_ACCEL_Y_OFFSET,   {16'($urandom), yo[15:0]});
    write_reg(REG_ACCEL_X_OFFSET,   {16'($urandom), xo[15:0]});
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Random settings; wide ones go past the documented ranges to the register width
  task automatic shuffle_settings(input bit wide);
    int span;
    span = wide ? 32768 : 16384;
    apply_settings(int'($urandom_range(0, 65535)) - 32768,
                   wide ? $urandom : $urandom_range(0, 40000000),
                   wide ? $urandom_range(0, 16383) : $urandom_range(0, RIGHT_ANGLE),
                   int'($urandom_range(0, 2 * span - 1)) - span,
                   int'($urandom_range(0, 2 * span - 1)) - span,
                   int'($urandom_range(0, 2 * span - 1)) - span,
                   int'($urandom_range(0, 2 * span)) - span,
                   int'($urandom_range(0, 2 * span)) - span);
  endtask

  initial begin
    rst         <= 1'b1;
    cfg_write   <= 1'b0;
    cfg_index   <= REG_GYRO_ZERO_Z;
    cfg_data    <= '0;
    smp.valid   <= 1'b0;
    smp.accel_x <= '0;
    smp.accel_y <= '0;
    smp.accel_z <= '0;
    smp.gyro_x  <= '0;
    smp.gyro_y  <= '0;
    smp.gyro_z  <= '0;
    burst_left = 0;
    settings_used = 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed samples under the reset settings
    send_frame(frame(0, 0, 0, 0, 0, 0));
    send_frame(frame(-1393, 1229, -16384, 0, 0, 0));       // upright
    send_frame(frame(-1393, 1229, 16384, 0, 0, 0));        // face up
    send_frame(frame(-1393, -16384, 0, 0, 0, 0));          // face down
    send_frame(frame(-16384, 1229, 0, 0, 0, 0));           // left side
    send_frame(frame(16384, 1229, -16384, 0, 0, 0));       // right side
    send_frame(frame(-1393, 1229, -10000, 0, 0, 0));       // no posture matches
    send_frame(frame(-16384, 1229, -16384, 0, 0, 0));      // left blocked by z
    send_frame(frame(0, 0, 0, 0, 0, 32767));               // turning one way
    send_frame(frame(0, 0, 0, 0, 0, -32768));              // and the other
    send_frame(frame(-32768, -32768, -32768, -32768, -32768, -32768));
    send_frame(frame(32767, 32767, 32767, 32767, 32767, 32767));
    send_frame(frame(14991, 17613, 0, 0, 0, 0));           // exactly one g: top of table
    send_frame(frame(14990, -15155, 0, 0, 0, 0));          // just below, and minus one g
    send_frame(frame(-17777, 17614, 0, 0, 0, 0));          // y past one g: clamped
    send_frame(frame(0, 0, 0, 0, 0, 3200));                // magnitude equals threshold
    send_frame(frame(0, 0, 0, 0, 0, 3201));                // just above it
    send_frame(frame(0, 0, 0, -3200, 0, 0));
    send_frame(frame(0, 0, 0, 32767, 0, 0));               // moving, no yaw rate
    send_frame(frame(0, 0, 0, -32768, 0, 7));              // small steps round to nearest
    send_frame(frame(0, 0, 0, -32768, 0, -3));
    send_frame(frame(0, 0, 0, 0, -32768, -1000));
    repeat (PER_SETTING) send_frame(random_frame());
    settle();

    // Low extremes: every nonzero gyro reading counts as motion
    apply_settings(-32768, 32'h0000_0000, 0, -32768, -32768, -32768, -16384, -16384);
    repeat (PER_SETTING) send_frame(random_frame());
    settle();

    // High extremes: nothing counts as motion
    apply_settings(32767, 32'hFFFF_FFFF, RIGHT_ANGLE, 32767, 32767, 32767, 16384, 16384);
    repeat (PER_SETTING) send_frame(random_frame());
    settle();

    repeat (3) begin
      shuffle_settings(1'b0);
      repeat (PER_SETTING) send_frame(random_frame());
      settle();
    end

    shuffle_settings(1'b1);
    repeat (PER_SETTING) send_frame(random_frame());
    settle();

    apply_settings(GYRO_ZERO_Z_RST, MOTION_THRESH_SQ_RST, ANGLE_LIMIT_RST,
                   Z_UPRIGHT_LIMIT_RST, Z_FACEUP_LIMIT_RST, Z_SIDE_LIMIT_RST,
                   ACCEL_Y_OFFSET_RST, ACCEL_X_OFFSET_RST);
    repeat (PER_SETTING) send_frame(random_frame());
    settle();
    repeat (8) @(posedge clk);

    $display("Run covered %0d samples and %0d results across %0d register settings,",
             samples_taken, results_seen, settings_used);
    $display("with bursty samples and a stalling result channel.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/imu_pc_pkg.sv
src/imu_pc_if.sv
src/imu_pc_asin.sv
src/imu_posture_classifier.sv
bench/imu_posture_checker.sv
bench/tb_imu_posture_classifier.sv
